FILE: design/imu_window_covariance_unit_macros.svh
// Assertion helpers shared by the covariance unit.
// Each macro takes a label, a condition, the expected consequence and a message.
`ifndef IMU_WINDOW_COVARIANCE_UNIT_MACROS_SVH
`define IMU_WINDOW_COVARIANCE_UNIT_MACROS_SVH

// Consequence must hold in the same cycle.
`define IWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the following cycle.
`define IWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/iwc_pkg.sv
package iwc_pkg;

    // Field and storage widths.
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 13;
    localparam int AXIS_W     = 29;
    localparam int PSUM_W     = 44;
    localparam int PSUM_LO_W  = 22;
    localparam int MOP_W      = 30;
    localparam int MPROD_W    = 60;
    localparam int N2_W       = 25;
    localparam int MAG_W      = 55;
    localparam int DIV_W      = 63;
    localparam int COV_W      = 40;
    localparam int NUM_PSUM   = 12;
    localparam int NUM_AXIS   = 6;

    localparam logic [LEN_W-1:0] MAX_WINDOW   = 13'd4096;
    localparam logic [LEN_W-1:0] MIN_WINDOW   = 13'd2;
    localparam logic [LEN_W-1:0] RESET_WINDOW = 13'd501;
    localparam logic [3:0]       LAST_PSTEP   = 4'd11;
    localparam logic [5:0]       LAST_DBIT    = 6'd62;

    // Axis and matrix codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic       MAT_GYRO  = 1'b0;
    localparam logic       MAT_ACCEL = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PMUL  = 11'b000_0000_0010,
        S_PACC  = 11'b000_0000_0100,
        S_N2MUL = 11'b000_0000_1000,
        S_N2W   = 11'b000_0001_0000,
        S_M1    = 11'b000_0010_0000,
        S_M2    = 11'b000_0100_0000,
        S_M3    = 11'b000_1000_0000,
        S_M4    = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    // Slot of the product sum for an axis pair within a triad.
    function automatic logic [2:0] pair_slot(input logic [1:0] i, input logic [1:0] j);
        logic [2:0] s;
        begin
            s = 3'd0;
            case ({i, j})
                {AXIS_X, AXIS_X}: s = 3'd0;
                {AXIS_X, AXIS_Y}, {AXIS_Y, AXIS_X}: s = 3'd1;
                {AXIS_X, AXIS_Z}, {AXIS_Z, AXIS_X}: s = 3'd2;
                {AXIS_Y, AXIS_Y}: s = 3'd3;
                {AXIS_Y, AXIS_Z}, {AXIS_Z, AXIS_Y}: s = 3'd4;
                {AXIS_Z, AXIS_Z}: s = 3'd5;
                default: s = 3'd0;
            endcase
            return s;
        end
    endfunction

    // First and second axis of a product slot.
    function automatic logic [1:0] slot_first(input logic [2:0] s);
        logic [1:0] a;
        begin
            case (s)
                3'd0, 3'd1, 3'd2: a = AXIS_X;
                3'd3, 3'd4:       a = AXIS_Y;
                default:          a = AXIS_Z;
            endcase
            return a;
        end
    endfunction

    function automatic logic [1:0] slot_second(input logic [2:0] s);
        logic [1:0] a;
        begin
            case (s)
                3'd0:       a = AXIS_X;
                3'd1, 3'd3: a = AXIS_Y;
                default:    a = AXIS_Z;
            endcase
            return a;
        end
    endfunction

    // Index of an axis within the six-axis sample.
    function automatic logic [2:0] axis_index(input logic mat, input logic [1:0] a);
        begin
            return mat ? (3'd3 + {1'b0, a}) : {1'b0, a};
        end
    endfunction

endpackage

FILE: design/imu_window_covariance_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | in        | in_valid / in_stall   | gyro_x..z, accel_x..z
// out     | out       | out_valid / out_stall | matrix_select, row_index, column_index,
//         |           |                       | cov_value, last_entry
// cfg     | in        | cfg_valid / cfg_ready | cfg_data (window_length)
//
// An item that does not close a window is accepted and then goes through
// twelve multiply and accumulate steps on the single shared 30x30 multiplier.
// A closing item then computes N squared and, for each of the 18 results per
// window, makes multiplier passes and a 63-step restoring divide, and waits
// while the output is stalled. Reset clears all sums and the count.
// The input is stalled throughout the work on an item.
`include "imu_window_covariance_unit_macros.svh"

module imu_window_covariance_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   gyro_x,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   gyro_y,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   gyro_z,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   accel_x,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   accel_y,
    input  logic signed [iwc_pkg::SAMPLE_W-1:0]   accel_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  matrix_select,
    output logic [1:0]                            row_index,
    output logic [1:0]                            column_index,
    output logic signed [iwc_pkg::COV_W-1:0]      cov_value,
    output logic                                  last_entry,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [iwc_pkg::LEN_W-1:0]             cfg_data
);

    iwc_pkg::state_t state_reg, state_next;

    logic [iwc_pkg::LEN_W-1:0]            win_len_reg;
    logic [iwc_pkg::LEN_W-1:0]            count_reg;
    logic signed [iwc_pkg::SAMPLE_W-1:0]  sample_reg   [iwc_pkg::NUM_AXIS];
    logic signed [iwc_pkg::AXIS_W-1:0]    axis_sum_reg [iwc_pkg::NUM_AXIS];
    logic signed [iwc_pkg::PSUM_W-1:0]    psum_reg     [iwc_pkg::NUM_PSUM];
    logic [3:0]                           step_reg;
    logic                                 mat_reg;
    logic [1:0]                           row_reg;
    logic [1:0]                           col_reg;
    logic [iwc_pkg::N2_W-1:0]             n2_reg;
    logic signed [iwc_pkg::MPROD_W-1:0]   mult_reg;
    logic signed [iwc_pkg::MPROD_W-1:0]   acc_reg;
    logic                                 neg_reg;
    logic [iwc_pkg::DIV_W-1:0]            div_reg;
    logic [iwc_pkg::N2_W-1:0]             rem_reg;
    logic [5:0]                           bit_reg;
    logic                                 out_valid_reg;
    logic                                 out_mat_reg;
    logic [1:0]                           out_row_reg;
    logic [1:0]                           out_col_reg;
    logic signed [iwc_pkg::COV_W-1:0]     out_cov_reg;
    logic                                 out_last_reg;

    logic                                 in_accept;
    logic                                 out_accept;
    logic [iwc_pkg::LEN_W-1:0]            eff_len;
    logic                                 step_hi;
    logic [2:0]                           step_slot;
    logic [2:0]                           res_slot;
    logic [3:0]                           psum_addr;
    logic signed [iwc_pkg::PSUM_W-1:0]    psum_rd;
    logic signed [iwc_pkg::MOP_W-1:0]     op_a;
    logic signed [iwc_pkg::MOP_W-1:0]     op_b;
    logic signed [iwc_pkg::MPROD_W-1:0]   mult_prod;
    logic signed [iwc_pkg::MPROD_W-1:0]   diff;
    logic [iwc_pkg::MPROD_W-1:0]          diff_mag;
    logic [iwc_pkg::N2_W:0]               rem_shift;
    logic                                 q_bit;
    logic [iwc_pkg::DIV_W-1:0]            div_next;
    logic [iwc_pkg::N2_W-1:0]             rem_next;
    logic [iwc_pkg::COV_W-1:0]            quot;
    logic                                 res_last;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = (state_reg != iwc_pkg::S_IDLE);
    assign cfg_ready  = 1'b1;

    // Clamp the window length to its legal range.
    always_comb
    begin
        if (win_len_reg < iwc_pkg::MIN_WINDOW)
            eff_len = iwc_pkg::MIN_WINDOW;
        else if (win_len_reg > iwc_pkg::MAX_WINDOW)
            eff_len = iwc_pkg::MAX_WINDOW;
        else
            eff_len = win_len_reg;
    end

    // Product-sum step decode and result slot.
    assign step_hi   = (step_reg >= 4'd6);
    assign step_slot = step_hi ? 3'(step_reg - 4'd6) : step_reg[2:0];
    assign res_slot  = iwc_pkg::pair_slot(row_reg, col_reg);
    assign psum_addr = (state_reg == iwc_pkg::S_PACC) ? step_reg
                     : (mat_reg ? (4'd6 + {1'b0, res_slot}) : {1'b0, res_slot});
    assign psum_rd   = psum_reg[psum_addr];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            iwc_pkg::S_PMUL:
            begin
                op_a = iwc_pkg::MOP_W'(sample_reg[iwc_pkg::axis_index(step_hi,
                           iwc_pkg::slot_first(step_slot))]);
                op_b = iwc_pkg::MOP_W'(sample_reg[iwc_pkg::axis_index(step_hi,
                           iwc_pkg::slot_second(step_slot))]);
            end
            iwc_pkg::S_N2MUL:
            begin
                op_a = signed'({{(iwc_pkg::MOP_W-iwc_pkg::LEN_W){1'b0}}, count_reg});
                op_b = signed'({{(iwc_pkg::MOP_W-iwc_pkg::LEN_W){1'b0}}, count_reg});
            end
            iwc_pkg::S_M1:
            begin
                op_a = signed'({{(iwc_pkg::MOP_W-iwc_pkg::LEN_W){1'b0}}, count_reg});
                op_b = iwc_pkg::MOP_W'(signed'(psum_rd[iwc_pkg::PSUM_W-1:iwc_pkg::PSUM_LO_W]));
            end
            iwc_pkg::S_M2:
            begin
                op_a = signed'({{(iwc_pkg::MOP_W-iwc_pkg::LEN_W){1'b0}}, count_reg});
                op_b = signed'({{(iwc_pkg::MOP_W-iwc_pkg::PSUM_LO_W){1'b0}},
                               psum_rd[iwc_pkg::PSUM_LO_W-1:0]});
            end
            iwc_pkg::S_M3:
            begin
                op_a = iwc_pkg::MOP_W'(axis_sum_reg[iwc_pkg::axis_index(mat_reg, row_reg)]);
                op_b = iwc_pkg::MOP_W'(axis_sum_reg[iwc_pkg::axis_index(mat_reg, col_reg)]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mult_prod = op_a * op_b;

    // Final difference and its magnitude.
    assign diff     = acc_reg - mult_reg;
    assign diff_mag = diff[iwc_pkg::MPROD_W-1] ? unsigned'(-diff) : unsigned'(diff);

    // One restoring divide step.
    always_comb
    begin
        rem_shift = {rem_reg, div_reg[iwc_pkg::DIV_W-1]};
        q_bit     = (rem_shift >= {1'b0, n2_reg});
        rem_next  = q_bit ? iwc_pkg::N2_W'(rem_shift - {1'b0, n2_reg})
                          : rem_shift[iwc_pkg::N2_W-1:0];
        div_next  = {div_reg[iwc_pkg::DIV_W-2:0], q_bit};
        quot      = div_next[iwc_pkg::COV_W-1:0];
    end

    assign res_last = (mat_reg == iwc_pkg::MAT_ACCEL) && (row_reg == iwc_pkg::AXIS_Z)
                   && (col_reg == iwc_pkg::AXIS_Z);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iwc_pkg::S_IDLE:  if (in_accept) state_next = iwc_pkg::S_PMUL;
            iwc_pkg::S_PMUL:  state_next = iwc_pkg::S_PACC;
            iwc_pkg::S_PACC:
            begin
                if (step_reg != iwc_pkg::LAST_PSTEP)
                    state_next = iwc_pkg::S_PMUL;
                else if (count_reg >= eff_len)
                    state_next = iwc_pkg::S_N2MUL;
                else
                    state_next = iwc_pkg::S_IDLE;
            end
            iwc_pkg::S_N2MUL: state_next = iwc_pkg::S_N2W;
            iwc_pkg::S_N2W:   state_next = iwc_pkg::S_M1;
            iwc_pkg::S_M1:    state_next = iwc_pkg::S_M2;
            iwc_pkg::S_M2:    state_next = iwc_pkg::S_M3;
            iwc_pkg::S_M3:    state_next = iwc_pkg::S_M4;
            iwc_pkg::S_M4:    state_next = iwc_pkg::S_DIV;
            iwc_pkg::S_DIV:   if (bit_reg == iwc_pkg::LAST_DBIT) state_next = iwc_pkg::S_OUT;
            iwc_pkg::S_OUT:
            begin
                if (out_accept)
                    state_next = out_last_reg ? iwc_pkg::S_IDLE : iwc_pkg::S_M1;
            end
            default:          state_next = iwc_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iwc_pkg::S_IDLE;
            win_len_reg   <= iwc_pkg::RESET_WINDOW;
            count_reg     <= '0;
            step_reg      <= '0;
            mat_reg       <= iwc_pkg::MAT_GYRO;
            row_reg       <= iwc_pkg::AXIS_X;
            col_reg       <= iwc_pkg::AXIS_X;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < iwc_pkg::NUM_AXIS; k++)
                axis_sum_reg[k] <= '0;
            for (int k = 0; k < iwc_pkg::NUM_PSUM; k++)
                psum_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                win_len_reg <= cfg_data;

            case (state_reg)
                iwc_pkg::S_IDLE:
                begin
                    // Take the item and add each axis to its sum.
                    if (in_accept)
                    begin
                        count_reg       <= count_reg + 13'd1;
                        step_reg        <= '0;
                        axis_sum_reg[0] <= axis_sum_reg[0] + iwc_pkg::AXIS_W'(gyro_x);
                        axis_sum_reg[1] <= axis_sum_reg[1] + iwc_pkg::AXIS_W'(gyro_y);
                        axis_sum_reg[2] <= axis_sum_reg[2] + iwc_pkg::AXIS_W'(gyro_z);
                        axis_sum_reg[3] <= axis_sum_reg[3] + iwc_pkg::AXIS_W'(accel_x);
                        axis_sum_reg[4] <= axis_sum_reg[4] + iwc_pkg::AXIS_W'(accel_y);
                        axis_sum_reg[5] <= axis_sum_reg[5] + iwc_pkg::AXIS_W'(accel_z);
                    end
                end
                iwc_pkg::S_PACC:
                begin
                    psum_reg[psum_addr] <= psum_rd + iwc_pkg::PSUM_W'(mult_reg);
                    step_reg            <= step_reg + 4'd1;
                    mat_reg             <= iwc_pkg::MAT_GYRO;
                    row_reg             <= iwc_pkg::AXIS_X;
                    col_reg             <= iwc_pkg::AXIS_X;
                end
                iwc_pkg::S_M4:
                begin
                    bit_reg <= '0;
                end
                iwc_pkg::S_DIV:
                begin
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == iwc_pkg::LAST_DBIT)
                        out_valid_reg <= 1'b1;
                end
                iwc_pkg::S_OUT:
                begin
                    // Advance to the next entry once this one is taken, or clear the window after the last.
                    if (out_accept)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            for (int k = 0; k < iwc_pkg::NUM_AXIS; k++)
                                axis_sum_reg[k] <= '0;
                            for (int k = 0; k < iwc_pkg::NUM_PSUM; k++)
                                psum_reg[k] <= '0;
                        end
                        else if (col_reg != iwc_pkg::AXIS_Z)
                            col_reg <= col_reg + 2'd1;
                        else
                        begin
                            col_reg <= iwc_pkg::AXIS_X;
                            if (row_reg != iwc_pkg::AXIS_Z)
                                row_reg <= row_reg + 2'd1;
                            else
                            begin
                                row_reg <= iwc_pkg::AXIS_X;
                                mat_reg <= iwc_pkg::MAT_ACCEL;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg[0] <= gyro_x;
            sample_reg[1] <= gyro_y;
            sample_reg[2] <= gyro_z;
            sample_reg[3] <= accel_x;
            sample_reg[4] <= accel_y;
            sample_reg[5] <= accel_z;
        end
        mult_reg <= mult_prod;
        case (state_reg)
            iwc_pkg::S_N2W:
                n2_reg <= mult_reg[iwc_pkg::N2_W-1:0];
            iwc_pkg::S_M2:
                acc_reg <= mult_reg <<< iwc_pkg::PSUM_LO_W;
            iwc_pkg::S_M3:
                acc_reg <= acc_reg + mult_reg;
            iwc_pkg::S_M4:
            begin
                neg_reg <= diff[iwc_pkg::MPROD_W-1];
                div_reg <= {diff_mag[iwc_pkg::MAG_W-1:0], 8'd0};
                rem_reg <= '0;
            end
            iwc_pkg::S_DIV:
            begin
                div_reg <= div_next;
                rem_reg <= rem_next;
                if (bit_reg == iwc_pkg::LAST_DBIT)
                begin
                    out_mat_reg  <= mat_reg;
                    out_row_reg  <= row_reg;
                    out_col_reg  <= col_reg;
                    out_cov_reg  <= neg_reg ? signed'(-quot) : signed'(quot);
                    out_last_reg <= res_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign matrix_select = out_mat_reg;
    assign row_index     = out_row_reg;
    assign column_index  = out_col_reg;
    assign cov_value     = out_cov_reg;
    assign last_entry    = out_last_reg;

    // The final flag marks only the bottom-right accel entry.
    `IWC_ASSERT_NOW(a_last_position, out_valid && last_entry,
        matrix_select && row_index == iwc_pkg::AXIS_Z && column_index == iwc_pkg::AXIS_Z,
        "last entry flagged at wrong position")
    // Taking the final entry clears the window and reopens the input.
    `IWC_ASSERT_NEXT(a_window_clear, out_valid && !out_stall && last_entry,
        !in_stall && count_reg == '0, "window not cleared after last entry")
    // A result is never shown while the input is open.
    `IWC_ASSERT_NOW(a_out_busy, out_valid, in_stall,
        "result shown while input is open")

endmodule
